FILE: hdl/dcpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcpm_pkg
// Types and constants for the depth-to-color pixel mapper: item structs,
// configuration register indexes, frame size and x offset segment table.
// ----------------------------------------------------------------------------
package dcpm_pkg;

    // Frame size
    parameter int FRAME_WIDTH  = 640;
    parameter int FRAME_HEIGHT = 480;

    parameter int COL_W   = 10;
    parameter int ROW_W   = 9;
    parameter int DEPTH_W = 15;
    parameter int SCALE_W = 16;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_X_SCALE    = 3'd0,
        CFG_Y_SCALE    = 3'd1,
        CFG_Y_OFFSET   = 3'd2,
        CFG_DEPTH_LOW  = 3'd3,
        CFG_DEPTH_HIGH = 3'd4,
        CFG_MIRROR_X   = 3'd5
    } cfg_index_t;

    // Register reset values
    parameter logic [15:0] X_SCALE_RST    = 16'd29065;
    parameter logic [15:0] Y_SCALE_RST    = 16'd28957;
    parameter logic [15:0] Y_OFFSET_RST   = 16'd4608;
    parameter logic [14:0] DEPTH_LOW_RST  = 15'd500;
    parameter logic [14:0] DEPTH_HIGH_RST = 15'd2000;
    parameter logic        MIRROR_X_RST   = 1'b1;

    // Offset segments: breakpoints in mm, slope Q.16, intercept signed Q6.16
    parameter logic [14:0] BREAK_0 = 15'd550;
    parameter logic [14:0] BREAK_1 = 15'd780;
    parameter logic [14:0] BREAK_2 = 15'd1020;
    parameter logic [14:0] BREAK_3 = 15'd1724;

    parameter int SLOPE_W = 12;
    parameter int ICPT_W  = 22;

    parameter logic [SLOPE_W-1:0] SEG1_SLOPE = 12'd2849;
    parameter logic [SLOPE_W-1:0] SEG2_SLOPE = 12'd1092;
    parameter logic [SLOPE_W-1:0] SEG3_SLOPE = 12'd279;

    parameter logic signed [ICPT_W-1:0] SEG1_ICPT      = -22'sd780730;
    parameter logic signed [ICPT_W-1:0] SEG2_ICPT      = 22'sd589804;
    parameter logic signed [ICPT_W-1:0] SEG3_ICPT      = 22'sd1419051;
    parameter logic signed [ICPT_W-1:0] CLAMP_LOW_Q16  = 22'sd786432;
    parameter logic signed [ICPT_W-1:0] CLAMP_HIGH_Q16 = 22'sd1900544;

    typedef struct packed {
        logic [COL_W-1:0]   pixel_col;
        logic [ROW_W-1:0]   pixel_row;
        logic [DEPTH_W-1:0] depth_mm;
    } in_item_t;

    typedef struct packed {
        logic             depth_ok;
        logic             in_frame;
        logic [COL_W-1:0] color_col;
        logic [ROW_W-1:0] color_row;
        logic [COL_W-1:0] source_col;
        logic [ROW_W-1:0] source_row;
    } out_item_t;

endpackage

FILE: hdl/depth_to_color_pixel_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_to_color_pixel_mapper
// Maps a depth pixel to its aligned color-image coordinate.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_item) takes one depth pixel per item:
//   column, row and depth in mm. Output channel (out_valid/out_ready/out_item)
//   gives one result item per input item, in order: depth flag, in-frame flag,
//   saturated color column and row, and the source column and row.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
//   write it only while no item is in flight. Unknown indexes are dropped.
// Pipeline: four register stages (range check and segment pick, three
//   multipliers, sums, truncate and saturate).
// Throughput: one item per cycle while out_ready stays high; the multiply stage sets the cycle budget.
// Reset: all pipeline stages empty, registers take their default values.
// Stall: each stage holds while the next is full and stalled; empty stages
//   keep filling, so in_ready drops only once every stage holds an item.
// ----------------------------------------------------------------------------
module depth_to_color_pixel_mapper
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  dcpm_pkg::in_item_t   in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output dcpm_pkg::out_item_t  out_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_data
);

    localparam int XP_W = 28;   // column times x scale, signed
    localparam int OP_W = 27;   // slope times depth
    localparam int YP_W = 25;   // row times y scale
    localparam int XQ_W = 29;   // x sum in Q.16
    localparam int YQ_W = 26;   // y sum in Q.15

    // Configuration registers
    logic [15:0] x_scale_reg, y_scale_reg, y_offset_reg;
    logic [14:0] depth_low_reg, depth_high_reg;
    logic        mirror_x_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_scale_reg    <= dcpm_pkg::X_SCALE_RST;
            y_scale_reg    <= dcpm_pkg::Y_SCALE_RST;
            y_offset_reg   <= dcpm_pkg::Y_OFFSET_RST;
            depth_low_reg  <= dcpm_pkg::DEPTH_LOW_RST;
            depth_high_reg <= dcpm_pkg::DEPTH_HIGH_RST;
            mirror_x_reg   <= dcpm_pkg::MIRROR_X_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (dcpm_pkg::cfg_index_t'(cfg_index))
                dcpm_pkg::CFG_X_SCALE:    x_scale_reg    <= cfg_data;
                dcpm_pkg::CFG_Y_SCALE:    y_scale_reg    <= cfg_data;
                dcpm_pkg::CFG_Y_OFFSET:   y_offset_reg   <= cfg_data;
                dcpm_pkg::CFG_DEPTH_LOW:  depth_low_reg  <= cfg_data[14:0];
                dcpm_pkg::CFG_DEPTH_HIGH: depth_high_reg <= cfg_data[14:0];
                dcpm_pkg::CFG_MIRROR_X:   mirror_x_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Stage advance chain: a stage loads when it is empty or its item moves on
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic adv1, adv2, adv3, adv_out;

    assign adv_out  = !out_valid_reg || out_ready;
    assign adv3     = !s3_valid_reg || adv_out;
    assign adv2     = !s2_valid_reg || adv3;
    assign adv1     = !s1_valid_reg || adv2;
    assign in_ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (adv_out)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Stage 1: depth window, segment pick, mirrored column
    logic                                 s1_ok_next;
    logic signed [dcpm_pkg::COL_W:0]      s1_c_next;
    logic [dcpm_pkg::SLOPE_W-1:0]         s1_slope_next;
    logic signed [dcpm_pkg::ICPT_W-1:0]   s1_icpt_next;

    always_comb
    begin
        s1_ok_next = (in_item.depth_mm > depth_low_reg) &&
                     (in_item.depth_mm < depth_high_reg);
        if (mirror_x_reg)
        begin
            s1_c_next = $signed((dcpm_pkg::COL_W+1)'(dcpm_pkg::FRAME_WIDTH)) -
                        $signed({1'b0, in_item.pixel_col});
        end
        else
        begin
            s1_c_next = $signed({1'b0, in_item.pixel_col});
        end

        priority if (in_item.depth_mm < dcpm_pkg::BREAK_0)
        begin
            s1_slope_next = '0;
            s1_icpt_next  = dcpm_pkg::CLAMP_LOW_Q16;
        end
        else if (in_item.depth_mm <= dcpm_pkg::BREAK_1)
        begin
            s1_slope_next = dcpm_pkg::SEG1_SLOPE;
            s1_icpt_next  = dcpm_pkg::SEG1_ICPT;
        end
        else if (in_item.depth_mm <= dcpm_pkg::BREAK_2)
        begin
            s1_slope_next = dcpm_pkg::SEG2_SLOPE;
            s1_icpt_next  = dcpm_pkg::SEG2_ICPT;
        end
        else if (in_item.depth_mm <= dcpm_pkg::BREAK_3)
        begin
            s1_slope_next = dcpm_pkg::SEG3_SLOPE;
            s1_icpt_next  = dcpm_pkg::SEG3_ICPT;
        end
        else
        begin
            s1_slope_next = '0;
            s1_icpt_next  = dcpm_pkg::CLAMP_HIGH_Q16;
        end
    end

    logic                               s1_ok_reg;
    logic signed [dcpm_pkg::COL_W:0]    s1_c_reg;
    logic [dcpm_pkg::SLOPE_W-1:0]       s1_slope_reg;
    logic signed [dcpm_pkg::ICPT_W-1:0] s1_icpt_reg;
    logic [dcpm_pkg::DEPTH_W-1:0]       s1_depth_reg;
    logic [dcpm_pkg::COL_W-1:0]         s1_col_reg;
    logic [dcpm_pkg::ROW_W-1:0]         s1_row_reg;

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_ok_reg    <= s1_ok_next;
            s1_c_reg     <= s1_c_next;
            s1_slope_reg <= s1_slope_next;
            s1_icpt_reg  <= s1_icpt_next;
            s1_depth_reg <= in_item.depth_mm;
            s1_col_reg   <= in_item.pixel_col;
            s1_row_reg   <= in_item.pixel_row;
        end
    end

    // Stage 2: the three products
    logic signed [XP_W-1:0]             s2_xprod_next;
    logic [OP_W-1:0]                    s2_oprod_next;
    logic [YP_W-1:0]                    s2_yprod_next;

    assign s2_xprod_next = XP_W'(s1_c_reg * $signed({1'b0, x_scale_reg}));
    assign s2_oprod_next = OP_W'(s1_slope_reg * s1_depth_reg);
    assign s2_yprod_next = YP_W'(s1_row_reg * y_scale_reg);

    logic                               s2_ok_reg;
    logic signed [XP_W-1:0]             s2_xprod_reg;
    logic [OP_W-1:0]                    s2_oprod_reg;
    logic [YP_W-1:0]                    s2_yprod_reg;
    logic signed [dcpm_pkg::ICPT_W-1:0] s2_icpt_reg;
    logic [dcpm_pkg::COL_W-1:0]         s2_col_reg;
    logic [dcpm_pkg::ROW_W-1:0]         s2_row_reg;

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            s2_ok_reg    <= s1_ok_reg;
            s2_xprod_reg <= s2_xprod_next;
            s2_oprod_reg <= s2_oprod_next;
            s2_yprod_reg <= s2_yprod_next;
            s2_icpt_reg  <= s1_icpt_reg;
            s2_col_reg   <= s1_col_reg;
            s2_row_reg   <= s1_row_reg;
        end
    end

    // Stage 3: sums in fixed point
    logic signed [XQ_W-1:0] s3_xq_next;
    logic [YQ_W-1:0]        s3_yq_next;

    assign s3_xq_next = (XQ_W'(s2_xprod_reg) <<< 1) +
                        $signed({{(XQ_W-OP_W){1'b0}}, s2_oprod_reg}) +
                        XQ_W'(s2_icpt_reg);
    assign s3_yq_next = YQ_W'(s2_yprod_reg) + YQ_W'({y_offset_reg, 7'b0});

    logic                       s3_ok_reg;
    logic signed [XQ_W-1:0]     s3_xq_reg;
    logic [YQ_W-1:0]            s3_yq_reg;
    logic [dcpm_pkg::COL_W-1:0] s3_col_reg;
    logic [dcpm_pkg::ROW_W-1:0] s3_row_reg;

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            s3_ok_reg  <= s2_ok_reg;
            s3_xq_reg  <= s3_xq_next;
            s3_yq_reg  <= s3_yq_next;
            s3_col_reg <= s2_col_reg;
            s3_row_reg <= s2_row_reg;
        end
    end

    // Stage 4: truncate toward zero and saturate to the frame
    logic signed [XQ_W-17:0] x_int;
    logic [YQ_W-16:0]        y_int;
    logic                    x_neg, x_neg_out, x_over, y_over;
    dcpm_pkg::out_item_t     out_item_next;

    always_comb
    begin
        x_int     = s3_xq_reg[XQ_W-1:16];
        y_int     = s3_yq_reg[YQ_W-1:15];
        x_neg     = s3_xq_reg[XQ_W-1];
        // a value in (-1,0) truncates to zero and stays in frame
        x_neg_out = s3_xq_reg < -XQ_W'(65535);
        x_over    = !x_neg && (x_int > $signed((XQ_W-16)'(dcpm_pkg::FRAME_WIDTH - 1)));
        y_over    = y_int > (YQ_W-15)'(dcpm_pkg::FRAME_HEIGHT - 1);

        out_item_next            = '0;
        out_item_next.depth_ok   = s3_ok_reg;
        out_item_next.source_col = s3_col_reg;
        out_item_next.source_row = s3_row_reg;
        if (s3_ok_reg)
        begin
            out_item_next.in_frame = !x_neg_out && !x_over && !y_over;
            priority if (x_neg)
            begin
                out_item_next.color_col = '0;
            end
            else if (x_over)
            begin
                out_item_next.color_col = dcpm_pkg::COL_W'(dcpm_pkg::FRAME_WIDTH - 1);
            end
            else
            begin
                out_item_next.color_col = x_int[dcpm_pkg::COL_W-1:0];
            end
            if (y_over)
            begin
                out_item_next.color_row = dcpm_pkg::ROW_W'(dcpm_pkg::FRAME_HEIGHT - 1);
            end
            else
            begin
                out_item_next.color_row = y_int[dcpm_pkg::ROW_W-1:0];
            end
        end
    end

    dcpm_pkg::out_item_t out_item_reg;

    always_ff @(posedge clk)
    begin
        if (adv_out)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Assertions
    a_invalid_depth_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.depth_ok |->
            !out_item.in_frame && out_item.color_col == '0 && out_item.color_row == '0)
        else $error("invalid depth item carries a coordinate");

    a_color_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            out_item.color_col <= dcpm_pkg::COL_W'(dcpm_pkg::FRAME_WIDTH - 1) &&
            out_item.color_row <= dcpm_pkg::ROW_W'(dcpm_pkg::FRAME_HEIGHT - 1))
        else $error("color coordinate not saturated to frame");

    a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("input blocked with first stage empty");

    a_last_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg && adv_out |=> out_valid)
        else $error("item lost between last stage and output");

    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg && out_valid && !out_ready |=> s3_valid_reg && $stable(s3_xq_reg))
        else $error("last stage changed while output stalled");

endmodule

FILE: bench/depth_to_color_pixel_mapper_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_to_color_pixel_mapper_tb
// Self-checking bench for the depth-to-color pixel mapper. Directed pixels
// cover the depth windows, the offset breakpoints, the clamps, the mirror
// and frame saturation. Random pixel streams under random register settings
// follow. The streams run with random stalls on both channels, then with
// none. A local fixed-point predictor computes each expected result item,
// and the bench compares the results in order.
// ----------------------------------------------------------------------------
module depth_to_color_pixel_mapper_tb;

    localparam int TIMEOUT_NS  = 5_000_000;
    localparam int TAIL_CYCLES = 12;
    localparam int BLOCKS      = 6;
    localparam int BLOCK_ITEMS = 62;

    // Indexes with no register behind them
    localparam logic [2:0] CFG_UNMAPPED_A = 3'd6;
    localparam logic [2:0] CFG_UNMAPPED_B = 3'd7;

    // x offset: breakpoints in mm, slopes in Q.16, intercepts in signed Q6.16
    localparam int      KNEE_A   = 550;
    localparam int      KNEE_B   = 780;
    localparam int      KNEE_C   = 1020;
    localparam int      KNEE_D   = 1724;
    localparam longint  RAMP_A_M = 2849;
    localparam longint  RAMP_A_Q = -780730;
    localparam longint  RAMP_B_M = 1092;
    localparam longint  RAMP_B_Q = 589804;
    localparam longint  RAMP_C_M = 279;
    localparam longint  RAMP_C_Q = 1419051;
    localparam longint  FLOOR_Q16 = 12 * 65536;
    localparam longint  CEIL_Q16  = 29 * 65536;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    dcpm_pkg::in_item_t  in_item;
    logic                out_valid;
    logic                out_ready;
    dcpm_pkg::out_item_t out_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    // Register shadow used by the predictor
    int cfg_x_scale    = 29065;
    int cfg_y_scale    = 28957;
    int cfg_y_offset   = 4608;
    int cfg_depth_low  = 500;
    int cfg_depth_high = 2000;
    int cfg_mirror     = 1;

    int send_idle_pct;
    int recv_idle_pct;
    int mismatch_count = 0;

    dcpm_pkg::out_item_t mapped_q[$];

    depth_to_color_pixel_mapper dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

    function automatic longint x_offset_q16(int d);
        if (d < KNEE_A)
            return FLOOR_Q16;
        if (d <= KNEE_B)
            return RAMP_A_M * d + RAMP_A_Q;
        if (d <= KNEE_C)
            return RAMP_B_M * d + RAMP_B_Q;
        if (d <= KNEE_D)
            return RAMP_C_M * d + RAMP_C_Q;
        return CEIL_Q16;
    endfunction

    function automatic longint clamp_coord(longint v, int size, inout logic fits);
        if (v < 0)
        begin
            fits = 1'b0;
            return 0;
        end
        if (v > size - 1)
        begin
            fits = 1'b0;
            return size - 1;
        end
        return v;
    endfunction

    function automatic dcpm_pkg::out_item_t map_pixel(dcpm_pkg::in_item_t px);
        dcpm_pkg::out_item_t r;
        longint    c;
        longint    xq;
        longint    yq;
        longint    xi;
        longint    yi;
        logic      fits;
        int        d;
        r = '0;
        d = int'(px.depth_mm);
        r.source_col = px.pixel_col;
        r.source_row = px.pixel_row;
        r.depth_ok = (d > cfg_depth_low) && (d < cfg_depth_high);
        if (r.depth_ok)
        begin
            c = longint'(cfg_mirror ? dcpm_pkg::FRAME_WIDTH - int'(px.pixel_col)
                                    : int'(px.pixel_col));
            xq = c * cfg_x_scale * 2 + x_offset_q16(d);
            yq = longint'(px.pixel_row) * cfg_y_scale + cfg_y_offset * 128;
            fits = 1'b1;
            // Division truncates toward zero, so (-1,0) lands on 0 in frame
            xi = clamp_coord(xq / 65536, dcpm_pkg::FRAME_WIDTH, fits);
            yi = clamp_coord(yq / 32768, dcpm_pkg::FRAME_HEIGHT, fits);
            r.in_frame  = fits;
            r.color_col = xi[dcpm_pkg::COL_W-1:0];
            r.color_row = yi[dcpm_pkg::ROW_W-1:0];
        end
        return r;
    endfunction

    task automatic compare_field(string field, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin : check_results
        dcpm_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (mapped_q.size() == 0)
            begin
                $error("result item with no pixel outstanding");
                mismatch_count++;
            end
            else
            begin
                want = mapped_q.pop_front();
                compare_field("depth_ok", 16'(want.depth_ok), 16'(out_item.depth_ok));
                compare_field("in_frame", 16'(want.in_frame), 16'(out_item.in_frame));
                compare_field("color_col", 16'(want.color_col), 16'(out_item.color_col));
                compare_field("color_row", 16'(want.color_row), 16'(out_item.color_row));
                compare_field("source_col", 16'(want.source_col),
                              16'(out_item.source_col));
                compare_field("source_row", 16'(want.source_row),
                              16'(out_item.source_row));
            end
        end
    end

    // Leaves in_valid high so the next pixel can follow without a bubble
    task automatic send_pixel(logic [dcpm_pkg::COL_W-1:0] col,
                              logic [dcpm_pkg::ROW_W-1:0] row,
                              logic [dcpm_pkg::DEPTH_W-1:0] depth);
        dcpm_pkg::in_item_t px;
        px.pixel_col = col;
        px.pixel_row = row;
        px.depth_mm  = depth;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= px;
        do @(posedge clk); while (!in_ready);
        mapped_q.insert(mapped_q.size(), map_pixel(px));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (mapped_q.size() != 0)
            @(posedge clk);
    endtask

    // Leaves cfg_valid high; the caller drops it after the last write
    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        unique case (idx)
            dcpm_pkg::CFG_X_SCALE:    cfg_x_scale    = val;
            dcpm_pkg::CFG_Y_SCALE:    cfg_y_scale    = val;
            dcpm_pkg::CFG_Y_OFFSET:   cfg_y_offset   = val;
            dcpm_pkg::CFG_DEPTH_LOW:  cfg_depth_low  = val[dcpm_pkg::DEPTH_W-1:0];
            dcpm_pkg::CFG_DEPTH_HIGH: cfg_depth_high = val[dcpm_pkg::DEPTH_W-1:0];
            dcpm_pkg::CFG_MIRROR_X:   cfg_mirror     = val[0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [15:0] kx, logic [15:0] ky, logic [15:0] cy,
                              logic [15:0] lo, logic [15:0] hi, logic [15:0] mir);
        write_reg(dcpm_pkg::CFG_X_SCALE, kx);
        write_reg(dcpm_pkg::CFG_Y_SCALE, ky);
        write_reg(dcpm_pkg::CFG_Y_OFFSET, cy);
        write_reg(dcpm_pkg::CFG_DEPTH_LOW, lo);
        write_reg(dcpm_pkg::CFG_DEPTH_HIGH, hi);
        write_reg(dcpm_pkg::CFG_MIRROR_X, mir);
        cfg_valid <= 1'b0;
    endtask

    // Reset register values; walk the depth window edges and every breakpoint
    task automatic test_default_map();
        send_pixel(10'd0,   9'd0,   15'd0);
        send_pixel(10'd639, 9'd479, 15'd500);
        send_pixel(10'd320, 9'd240, 15'd501);
        send_pixel(10'd0,   9'd0,   15'd549);
        send_pixel(10'd1,   9'd1,   15'd550);
        send_pixel(10'd639, 9'd479, 15'd780);
        send_pixel(10'd100, 9'd200, 15'd781);
        send_pixel(10'd200, 9'd100, 15'd1020);
        send_pixel(10'd300, 9'd300, 15'd1021);
        send_pixel(10'd400, 9'd400, 15'd1724);
        send_pixel(10'd500, 9'd450, 15'd1725);
        send_pixel(10'd638, 9'd478, 15'd1999);
        send_pixel(10'd10,  9'd10,  15'd2000);
        // Column past the frame goes negative under the mirror
        send_pixel(10'd1023, 9'd511, 15'd1200);
        send_pixel(10'd0,   9'd0,   15'd32767);
        drain();
    endtask

    task automatic test_limit_crossing();
        set_config(16'd29065, 16'd28957, 16'd4608, 16'd2000, 16'd500, 16'd1);
        send_pixel(10'd320, 9'd240, 15'd1000);
        send_pixel(10'd320, 9'd240, 15'd1500);
        drain();
        // Widest window, no mirror, upper register bits set on the limits
        set_config(16'd29065, 16'd28957, 16'd4608, 16'h8000, 16'hFFFF, 16'hFFFE);
        send_pixel(10'd0,   9'd0,   15'd0);
        send_pixel(10'd639, 9'd479, 15'd32766);
        send_pixel(10'd5,   9'd5,   15'd1);
        drain();
    endtask

    task automatic test_scale_extremes();
        set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd32767, 16'd0);
        send_pixel(10'd639, 9'd479, 15'd1000);
        drain();
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd32767, 16'd0);
        send_pixel(10'd639, 9'd479, 15'd600);
        send_pixel(10'd0,   9'd0,   15'd1500);
        drain();
        // x just below zero truncates to 0 and stays in frame
        set_config(16'd31000, 16'd28957, 16'd4608, 16'd500, 16'd2000, 16'd1);
        send_pixel(10'd653, 9'd10, 15'd520);
        drain();
    endtask

    task automatic test_unmapped_index();
        write_reg(CFG_UNMAPPED_A, 16'hFFFF);
        write_reg(CFG_UNMAPPED_B, 16'h0000);
        cfg_valid <= 1'b0;
        send_pixel(10'd320, 9'd240, 15'd900);
        drain();
    endtask

    task automatic load_random_config();
        logic [15:0] kx;
        logic [15:0] ky;
        logic [15:0] cy;
        logic [15:0] lo;
        logic [15:0] hi;
        kx = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(22000, 36000));
        ky = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(22000, 36000));
        cy = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12800));
        lo = {1'($urandom), 15'($urandom_range(0, 900))};
        hi = ($urandom_range(9) == 0) ? 16'($urandom)
                                      : {1'($urandom), 15'($urandom_range(1400, 4000))};
        set_config(kx, ky, cy, lo, hi, 16'($urandom));
    endtask

    function automatic logic [dcpm_pkg::DEPTH_W-1:0] pick_depth();
        int knee[4] = '{KNEE_A, KNEE_B, KNEE_C, KNEE_D};
        unique case ($urandom_range(11))
            0: return dcpm_pkg::DEPTH_W'($urandom);
            1: return dcpm_pkg::DEPTH_W'(knee[$urandom_range(3)] + $urandom_range(2) - 1);
            2: return dcpm_pkg::DEPTH_W'($urandom_range(1) ? cfg_depth_low
                                                             : cfg_depth_high);
            default:
                if (cfg_depth_high - cfg_depth_low >= 2)
                    return dcpm_pkg::DEPTH_W'($urandom_range(cfg_depth_high - 1,
                                                             cfg_depth_low + 1));
                else
                    return dcpm_pkg::DEPTH_W'($urandom);
        endcase
    endfunction

    task automatic test_random_stream(int send_pct, int recv_pct);
        logic [dcpm_pkg::COL_W-1:0] col;
        logic [dcpm_pkg::ROW_W-1:0] row;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int b = 0; b < BLOCKS; b++)
        begin
            load_random_config();
            for (int n = 0; n < BLOCK_ITEMS; n++)
            begin
                col = ($urandom_range(19) < 17)
                    ? dcpm_pkg::COL_W'($urandom_range(dcpm_pkg::FRAME_WIDTH - 1))
                    : dcpm_pkg::COL_W'($urandom);
                row = ($urandom_range(19) < 17)
                    ? dcpm_pkg::ROW_W'($urandom_range(dcpm_pkg::FRAME_HEIGHT - 1))
                    : dcpm_pkg::ROW_W'($urandom);
                send_pixel(col, row, pick_depth());
            end
            drain();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        send_idle_pct = 29;
        recv_idle_pct = 81;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_default_map();
        test_limit_crossing();
        test_scale_extremes();
        test_unmapped_index();
        test_random_stream(29, 81);
        test_random_stream(81, 29);
        test_random_stream(0, 0);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
